@@ hw/rtl/tse_pkg.sv @@
// ----------------------------------------------------------------------------
// tse_pkg
// Shared types and constants for the TLS server name extractor.
// ----------------------------------------------------------------------------
package tse_pkg;

  // Record and handshake codes
  localparam logic [7:0] REC_TYPE_HANDSHAKE = 8'h16;
  localparam logic [7:0] HS_TYPE_CLIENT_HELLO = 8'h01;
  localparam logic [7:0] ENTRY_TYPE_HOST_NAME = 8'h00;
  // Server name extension type is 0x0000, checked one byte at a time
  localparam logic [7:0] EXT_TYPE_SNI_BYTE = 8'h00;
  // Version (2) plus random (32)
  localparam int unsigned RANDOM_FIELD_LEN = 2 + 32;
  localparam int unsigned REC_HEADER_LEN = 5;
  localparam int unsigned HS_HEADER_LEN = 4;

  // Result verdict codes
  typedef enum logic [1:0] {
    VERDICT_MORE = 2'd0,
    VERDICT_DONE = 2'd1,
    VERDICT_FAIL = 2'd2
  } verdict_t;

  // One input word
  typedef struct packed {
    logic        last_byte;
    logic [15:0] packet_length;
    logic [7:0]  data_byte;
  } in_item_t;

  // One parser result
  typedef struct packed {
    logic        have;
    logic [7:0]  name_char;
    logic        char_valid;
    verdict_t    verdict;
    logic        last;
  } result_t;

endpackage

@@ hw/rtl/tls_sni_extractor.sv @@
// ----------------------------------------------------------------------------
// tls_sni_extractor
// Streams out a TLS ClientHello server name, one byte a cycle unless stalled.
// ----------------------------------------------------------------------------
//  Channel   Dir  Handshake                     Contents
//  s_axis    in   s_axis_tvalid/s_axis_tready   data_byte, packet_length, last_byte
//  m_axis    out  m_axis_tvalid/m_axis_tready   name_char, char_valid, verdict, last
//  cfg       in   cfg_valid/cfg_ready           name_buffer_size
//
//  One byte per cycle sustained while the sink takes results; each byte gives
//  zero or one result word. Path: input register, then parse logic into the
//  result register. The parse state registers update once per consumed byte.
//  A stalled sink holds the result register; the input register then fills
//  and s_axis_tready drops. cfg_ready is always high.
//  Reset: parser rearmed, name_buffer_size = 256, both registers empty.
// ----------------------------------------------------------------------------
module tls_sni_extractor
  import tse_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,  // [7:0] data_byte, [23:8] packet_length
  input  logic        s_axis_tlast,  // last_byte
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // [7:0] name_char
  output logic [2:0]  m_axis_tuser,  // [0] char_valid, [2:1] verdict
  output logic        m_axis_tlast,  // last
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [8:0]  cfg_data       // name_buffer_size
);

  in_item_t   in_item;
  in_item_t   item;
  logic       item_valid;
  logic       advance;
  result_t    res;
  logic [7:0] name_limit;

  assign in_item.data_byte     = s_axis_tdata[7:0];
  assign in_item.packet_length = s_axis_tdata[23:8];
  assign in_item.last_byte     = s_axis_tlast;

  // Name byte limit (size minus one, size clamped to 1..256)
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      name_limit <= 8'hFF;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_data[8]) begin
        name_limit <= 8'hFF;
      end else if (cfg_data[7:0] == '0) begin
        name_limit <= '0;
      end else begin
        name_limit <= cfg_data[7:0] - 8'd1;
      end
    end
  end

  // Consume the held word when the result register has room
  assign advance = item_valid && (!m_axis_tvalid || m_axis_tready);

  tse_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  tse_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk        (clk),
    .rst        (rst),
    .advance    (advance),
    .item       (item),
    .name_limit (name_limit),
    .res        (res)
  );

  tse_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (advance && res.have),
    .res       (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata),
    .out_user  (m_axis_tuser),
    .out_last  (m_axis_tlast)
  );

  // A name byte never comes with a failure verdict
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tuser[2:1] != VERDICT_FAIL)
    else $error("name byte carries failure verdict");

  // Final result of a packet is exactly a done or failure verdict
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tlast == (m_axis_tuser[2:1] != VERDICT_MORE)))
    else $error("last flag disagrees with verdict");

  // Input never stalls while the result register is empty
  assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty result register");

endmodule

@@ hw/rtl/tse_in_stage.sv @@
// ----------------------------------------------------------------------------
// tse_in_stage
// Input register: holds one word until the parser consumes it.
// ----------------------------------------------------------------------------
module tse_in_stage
  import tse_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_item,
  input  logic     advance,
  output logic     item_valid,
  output in_item_t item
);

  // Take a new word when empty or when the held one moves on
  assign in_ready = !item_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

@@ hw/rtl/tse_parser.sv @@
// ----------------------------------------------------------------------------
// tse_parser
// ClientHello walker: parse state registers and one-byte next-state logic.
// ----------------------------------------------------------------------------
module tse_parser
  import tse_pkg::*;
#(
  parameter int LENGTH_BITS = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       advance,
  input  in_item_t   item,
  input  logic [7:0] name_limit,
  output result_t    res
);

  localparam int L  = LENGTH_BITS;
  localparam int SW = ((L > 16) ? L : 16) + 2;

  typedef enum logic [4:0] {
    PH_REC_TYPE, PH_REC_SKIP, PH_REC_LEN_HI, PH_REC_LEN_LO, PH_HS_TYPE,
    PH_HS_LEN, PH_RANDOM, PH_SID_LEN, PH_SID, PH_CS_HI, PH_CS_LO, PH_CS,
    PH_COMP_LEN, PH_COMP, PH_EXTS_HI, PH_EXTS_LO, PH_EXT_TYPE_HI,
    PH_EXT_TYPE_LO, PH_EXT_LEN_HI, PH_EXT_LEN_LO, PH_EXT_SKIP, PH_LIST_HI,
    PH_LIST_LO, PH_ENTRY_TYPE, PH_ENTRY_LEN_HI, PH_ENTRY_LEN_LO,
    PH_ENTRY_SKIP, PH_NAME, PH_DONE
  } phase_t;

  // Parse state
  logic [L-1:0] byte_position, byte_position_next;
  phase_t       phase, phase_next;
  logic [L-1:0] field_remaining, field_remaining_next;
  logic [7:0]   length_high_byte, length_high_byte_next;
  logic [L-1:0] extensions_end, extensions_end_next;
  logic [L-1:0] cur_ext_end, cur_ext_end_next;
  logic [L-1:0] name_list_end, name_list_end_next;
  logic         ext_is_sni, ext_is_sni_next;
  logic         entry_is_host, entry_is_host_next;
  logic [7:0]   copy_remaining, copy_remaining_next;
  logic         verdict_given, verdict_given_next;

  // Operands
  logic [7:0]    b;
  logic [15:0]   v16;
  logic [SW-1:0] pos_ext, len_ext, v_ext, b_ext;
  logic [SW-1:0] ee_ext, cee_ext, nle_ext;
  logic [SW-1:0] pos_plus_v, pos_plus_b;
  logic [L-1:0]  fr_dec;
  logic          skip_end;
  logic          top_ok, entry_ok, rest_skip, rest_ok;
  phase_t        rest_phase;
  logic [L-1:0]  rest_fr;
  logic [7:0]    copy_cnt;
  logic [7:0]    cr_dec;

  assign b          = item.data_byte;
  assign v16        = {length_high_byte, b};
  assign pos_ext    = SW'(byte_position) + SW'(1);
  assign len_ext    = SW'(item.packet_length[L-1:0]);
  assign v_ext      = SW'(v16);
  assign b_ext      = SW'(b);
  assign ee_ext     = SW'(extensions_end);
  assign cee_ext    = SW'(cur_ext_end);
  assign nle_ext    = SW'(name_list_end);
  assign pos_plus_v = pos_ext + v_ext;
  assign pos_plus_b = pos_ext + b_ext;

  // Skip countdown
  assign fr_dec   = (field_remaining != '0) ? field_remaining - 1'b1 : '0;
  assign skip_end = (fr_dec == '0);

  // Where the walk goes next: next extension header, rest of extension
  assign top_ok     = (pos_ext + SW'(4)) <= ee_ext;
  assign entry_ok   = (pos_ext + SW'(3)) <= nle_ext;
  assign rest_skip  = cee_ext > pos_ext;
  assign rest_fr    = L'(cee_ext - pos_ext);
  assign rest_ok    = rest_skip || top_ok;
  assign rest_phase = rest_skip ? PH_EXT_SKIP : PH_EXT_TYPE_HI;

  // Name copy length, clipped to the buffer limit
  assign copy_cnt = (v16 > 16'(name_limit)) ? name_limit : v16[7:0];
  assign cr_dec   = (copy_remaining != '0) ? copy_remaining - 1'b1 : '0;

  // Next-state and result logic for one byte
  always_comb begin
    logic     ok;
    logic     have;
    logic     valid;
    logic [7:0] ch;
    verdict_t verd;

    ok    = 1'b1;
    have  = 1'b0;
    valid = 1'b0;
    ch    = '0;
    verd  = VERDICT_MORE;

    byte_position_next    = byte_position;
    phase_next            = phase;
    field_remaining_next  = field_remaining;
    length_high_byte_next = length_high_byte;
    extensions_end_next   = extensions_end;
    cur_ext_end_next      = cur_ext_end;
    name_list_end_next    = name_list_end;
    ext_is_sni_next       = ext_is_sni;
    entry_is_host_next    = entry_is_host;
    copy_remaining_next   = copy_remaining;
    verdict_given_next    = verdict_given;

    if (!verdict_given) begin
      case (phase)
        PH_REC_TYPE: begin
          if (len_ext < SW'(REC_HEADER_LEN) || b != REC_TYPE_HANDSHAKE) begin
            ok = 1'b0;
          end else begin
            field_remaining_next = L'(2);
            phase_next = PH_REC_SKIP;
          end
        end
        PH_REC_SKIP: begin
          field_remaining_next = fr_dec;
          if (skip_end) phase_next = PH_REC_LEN_HI;
        end
        PH_REC_LEN_LO: begin
          ok = ((v_ext + SW'(REC_HEADER_LEN)) <= len_ext) &&
               ((pos_ext + SW'(HS_HEADER_LEN)) <= len_ext);
          phase_next = PH_HS_TYPE;
        end
        PH_HS_TYPE: begin
          if (b != HS_TYPE_CLIENT_HELLO) begin
            ok = 1'b0;
          end else begin
            field_remaining_next = L'(3);
            phase_next = PH_HS_LEN;
          end
        end
        PH_HS_LEN: begin
          field_remaining_next = fr_dec;
          if (skip_end) begin
            ok = (pos_ext + SW'(RANDOM_FIELD_LEN)) <= len_ext;
            field_remaining_next = L'(RANDOM_FIELD_LEN);
            phase_next = PH_RANDOM;
          end
        end
        PH_RANDOM: begin
          field_remaining_next = fr_dec;
          if (skip_end) begin
            ok = (pos_ext + SW'(1)) <= len_ext;
            phase_next = PH_SID_LEN;
          end
        end
        PH_SID_LEN: begin
          if (pos_plus_b > len_ext) begin
            ok = 1'b0;
          end else if (b == '0) begin
            ok = (pos_ext + SW'(2)) <= len_ext;
            phase_next = PH_CS_HI;
          end else begin
            field_remaining_next = L'(b);
            phase_next = PH_SID;
          end
        end
        PH_SID: begin
          field_remaining_next = fr_dec;
          if (skip_end) begin
            ok = (pos_ext + SW'(2)) <= len_ext;
            phase_next = PH_CS_HI;
          end
        end
        PH_CS_LO: begin
          if (pos_plus_v > len_ext) begin
            ok = 1'b0;
          end else if (v16 == '0) begin
            ok = (pos_ext + SW'(1)) <= len_ext;
            phase_next = PH_COMP_LEN;
          end else begin
            field_remaining_next = v16[L-1:0];
            phase_next = PH_CS;
          end
        end
        PH_CS: begin
          field_remaining_next = fr_dec;
          if (skip_end) begin
            ok = (pos_ext + SW'(1)) <= len_ext;
            phase_next = PH_COMP_LEN;
          end
        end
        PH_COMP_LEN: begin
          if (pos_plus_b > len_ext) begin
            ok = 1'b0;
          end else if (b == '0) begin
            ok = (pos_ext + SW'(2)) <= len_ext;
            phase_next = PH_EXTS_HI;
          end else begin
            field_remaining_next = L'(b);
            phase_next = PH_COMP;
          end
        end
        PH_COMP: begin
          field_remaining_next = fr_dec;
          if (skip_end) begin
            ok = (pos_ext + SW'(2)) <= len_ext;
            phase_next = PH_EXTS_HI;
          end
        end
        PH_EXTS_LO: begin
          if (pos_plus_v > len_ext) begin
            ok = 1'b0;
          end else begin
            extensions_end_next = pos_plus_v[L-1:0];
            // header of the first extension must fit
            ok = (v16 >= 16'd4);
            phase_next = PH_EXT_TYPE_HI;
          end
        end
        PH_EXT_TYPE_LO: begin
          ext_is_sni_next = (length_high_byte == EXT_TYPE_SNI_BYTE) &&
                            (b == EXT_TYPE_SNI_BYTE);
          phase_next = PH_EXT_LEN_HI;
        end
        PH_EXT_LEN_LO: begin
          if (pos_plus_v > ee_ext) begin
            ok = 1'b0;
          end else begin
            cur_ext_end_next = pos_plus_v[L-1:0];
            if (!ext_is_sni) begin
              if (v16 == '0) begin
                ok = top_ok;
                phase_next = PH_EXT_TYPE_HI;
              end else begin
                field_remaining_next = v16[L-1:0];
                phase_next = PH_EXT_SKIP;
              end
            end else if (v16 < 16'd2) begin
              ok = 1'b0;
            end else begin
              phase_next = PH_LIST_HI;
            end
          end
        end
        PH_EXT_SKIP: begin
          field_remaining_next = fr_dec;
          if (skip_end) begin
            ok = top_ok;
            phase_next = PH_EXT_TYPE_HI;
          end
        end
        PH_LIST_LO: begin
          if (pos_plus_v > cee_ext) begin
            ok = 1'b0;
          end else begin
            name_list_end_next = pos_plus_v[L-1:0];
            if (v16 >= 16'd3) begin
              phase_next = PH_ENTRY_TYPE;
            end else begin
              ok = rest_ok;
              field_remaining_next = rest_fr;
              phase_next = rest_phase;
            end
          end
        end
        PH_ENTRY_TYPE: begin
          entry_is_host_next = (b == ENTRY_TYPE_HOST_NAME);
          phase_next = PH_ENTRY_LEN_HI;
        end
        PH_ENTRY_LEN_LO: begin
          if (pos_plus_v > nle_ext) begin
            ok = 1'b0;
          end else if (entry_is_host) begin
            if (copy_cnt == '0) begin
              have = 1'b1;
              verd = VERDICT_DONE;
            end else begin
              copy_remaining_next = copy_cnt;
              phase_next = PH_NAME;
            end
          end else if (v16 == '0) begin
            if (entry_ok) begin
              phase_next = PH_ENTRY_TYPE;
            end else begin
              ok = rest_ok;
              field_remaining_next = rest_fr;
              phase_next = rest_phase;
            end
          end else begin
            field_remaining_next = v16[L-1:0];
            phase_next = PH_ENTRY_SKIP;
          end
        end
        PH_ENTRY_SKIP: begin
          field_remaining_next = fr_dec;
          if (skip_end) begin
            if (entry_ok) begin
              phase_next = PH_ENTRY_TYPE;
            end else begin
              ok = rest_ok;
              field_remaining_next = rest_fr;
              phase_next = rest_phase;
            end
          end
        end
        PH_NAME: begin
          have  = 1'b1;
          valid = 1'b1;
          ch    = b;
          copy_remaining_next = cr_dec;
          verd  = (cr_dec == '0) ? VERDICT_DONE : VERDICT_MORE;
        end
        PH_REC_LEN_HI, PH_CS_HI, PH_EXTS_HI, PH_EXT_TYPE_HI, PH_EXT_LEN_HI,
        PH_LIST_HI, PH_ENTRY_LEN_HI: begin
          length_high_byte_next = b;
          phase_next = phase_t'(phase + 5'd1);
        end
        default: begin
          ok = 1'b0;
        end
      endcase

      // Any failed check gives the failure result
      if (!ok) begin
        have  = 1'b1;
        valid = 1'b0;
        ch    = '0;
        verd  = VERDICT_FAIL;
      end
      if (have && verd != VERDICT_MORE) begin
        verdict_given_next = 1'b1;
        phase_next = PH_DONE;
      end

      // Byte counter saturates at the top of the length range
      byte_position_next = (pos_ext[SW-1:L] != '0) ? '1 : pos_ext[L-1:0];

      // Packet ended before any verdict
      if (item.last_byte && !verdict_given_next) begin
        have  = 1'b1;
        valid = 1'b0;
        ch    = '0;
        verd  = VERDICT_FAIL;
        verdict_given_next = 1'b1;
      end
    end

    // Rearm after the last byte
    if (item.last_byte) begin
      byte_position_next    = '0;
      phase_next            = PH_REC_TYPE;
      field_remaining_next  = '0;
      length_high_byte_next = '0;
      extensions_end_next   = '0;
      cur_ext_end_next      = '0;
      name_list_end_next    = '0;
      ext_is_sni_next       = 1'b0;
      entry_is_host_next    = 1'b0;
      copy_remaining_next   = '0;
      verdict_given_next    = 1'b0;
    end

    res.have       = have;
    res.name_char  = ch;
    res.char_valid = valid;
    res.verdict    = verd;
    res.last       = (verd != VERDICT_MORE);
  end

  // State registers, updated once per consumed word
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position    <= '0;
      phase            <= PH_REC_TYPE;
      field_remaining  <= '0;
      length_high_byte <= '0;
      extensions_end   <= '0;
      cur_ext_end      <= '0;
      name_list_end    <= '0;
      ext_is_sni       <= 1'b0;
      entry_is_host    <= 1'b0;
      copy_remaining   <= '0;
      verdict_given    <= 1'b0;
    end else if (advance) begin
      byte_position    <= byte_position_next;
      phase            <= phase_next;
      field_remaining  <= field_remaining_next;
      length_high_byte <= length_high_byte_next;
      extensions_end   <= extensions_end_next;
      cur_ext_end      <= cur_ext_end_next;
      name_list_end    <= name_list_end_next;
      ext_is_sni       <= ext_is_sni_next;
      entry_is_host    <= entry_is_host_next;
      copy_remaining   <= copy_remaining_next;
      verdict_given    <= verdict_given_next;
    end
  end

endmodule

@@ hw/rtl/tse_out_stage.sv @@
// ----------------------------------------------------------------------------
// tse_out_stage
// Result register: holds one result until the sink takes it.
// ----------------------------------------------------------------------------
module tse_out_stage
  import tse_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       load,
  input  result_t    res,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_data,  // [7:0] name_char
  output logic [2:0] out_user,  // [0] char_valid, [2:1] verdict
  output logic       out_last   // last
);

  // Valid flag: set on load, cleared when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res.name_char;
      out_user <= {res.verdict, res.char_valid};
      out_last <= res.last;
    end
  end

endmodule
